@@ hdl/key_value_config_parser_macros.svh @@
// assertion macros for the key/value config parser checker
// expects clk and arst_n in the scope where a macro is used
`ifndef KEY_VALUE_CONFIG_PARSER_MACROS_SVH
`define KEY_VALUE_CONFIG_PARSER_MACROS_SVH

// property checked on every rising clock edge outside reset
`define KVCP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define KVCP_ASSERT_NEXT(label, pre, post, msg) \
	`KVCP_ASSERT(label, (pre) |=> (post), msg)

`endif

@@ hdl/kvcp_pkg.sv @@
// shared types, constants and keyword helpers for the key/value config parser
// no dependencies
package kvcp_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int COUNT_BITS_DEF = 16;

	// fixed widths of the result fields
	localparam int OUT_VALUE_W = 32;
	localparam int OUT_COUNT_W = 16;

	localparam logic [7:0] CH_END   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_EQUAL = 8'h3D;

	localparam logic [3:0] KEY_LEN_SHORT = 4'd4;
	localparam logic [3:0] KEY_LEN_LONG  = 4'd7;
	localparam logic [3:0] KEY_POS_MAX   = 4'hF;

	// candidate flag positions
	localparam int FLAG_BAUD    = 0;
	localparam int FLAG_RETRIES = 1;
	localparam int FLAG_ECHO    = 2;

	localparam logic [2:0] FLAGS_ALL   = 3'b111;
	localparam logic [2:0] FLAGS_SHORT = 3'b101;
	localparam logic [2:0] FLAGS_LONG  = 3'b010;
	localparam logic [2:0] FLAGS_NONE  = 3'b000;

	localparam logic [7:0] KW_BAUD [4]    = '{"b", "a", "u", "d"};
	localparam logic [7:0] KW_ECHO [4]    = '{"e", "c", "h", "o"};
	localparam logic [7:0] KW_RETRIES [8] = '{"r", "e", "t", "r", "i", "e", "s", 8'h00};

	typedef enum logic [1:0] {
		PH_KEY   = 2'd0,
		PH_VALUE = 2'd1,
		PH_SKIP  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [OUT_VALUE_W-1:0] baud;
		logic [OUT_VALUE_W-1:0] retries;
		logic                   echo;
		logic [OUT_COUNT_W-1:0] count;
	} result_t;

	// which keywords still match when byte c sits at key position pos
	function automatic logic [2:0] kw_keep(input logic [3:0] pos, input logic [7:0] c);
		logic [2:0] keep;
		keep = FLAGS_NONE;
		keep[FLAG_BAUD]    = (pos < KEY_LEN_SHORT) && (KW_BAUD[pos[1:0]] == c);
		keep[FLAG_ECHO]    = (pos < KEY_LEN_SHORT) && (KW_ECHO[pos[1:0]] == c);
		keep[FLAG_RETRIES] = (pos < KEY_LEN_LONG) && (KW_RETRIES[pos[2:0]] == c);
		return keep;
	endfunction

endpackage

@@ hdl/kvcp_if.sv @@
// valid/ready channel interfaces for the config byte input and the result output
// depends on kvcp_pkg
interface kvcp_in_if;
	import kvcp_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink (input valid, input char_byte, output ready);
	modport mon (input valid, input char_byte, input ready);
endinterface

interface kvcp_out_if;
	import kvcp_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [OUT_VALUE_W-1:0] baud_value;
	logic [OUT_VALUE_W-1:0] retries_value;
	logic                   echo_enabled;
	logic [OUT_COUNT_W-1:0] pairs_counted;

	modport source (output valid, output baud_value, output retries_value,
		output echo_enabled, output pairs_counted, input ready);
	modport sink (input valid, input baud_value, input retries_value,
		input echo_enabled, input pairs_counted, output ready);
	modport mon (input valid, input baud_value, input retries_value,
		input echo_enabled, input pairs_counted, input ready);
endinterface

@@ hdl/key_value_config_parser.sv @@
// streaming key=value config parser, one byte per cycle
// a zero byte passes through the input register, then its result is loaded into the result register
// throughput: one byte per cycle; the only stall is a zero byte meeting a full,
// unread result register
// reset clears parse state, pair count and the stored baud, retries and echo settings
module key_value_config_parser #(
	parameter int VALUE_BITS = kvcp_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = kvcp_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	kvcp_in_if.sink     in_ch,
	kvcp_out_if.source  out_ch
);
	import kvcp_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       advance;
	logic       emit;
	logic       out_free;
	result_t    result;

	// a non-terminating byte never needs the result register
	assign advance = valid_s1 && ((char_s1 != CH_END) || out_free);

	kvcp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.char_s1  (char_s1)
	);

	kvcp_parse_core #(
		.VALUE_BITS (VALUE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_parse_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.char_s1 (char_s1),
		.emit    (emit),
		.result  (result)
	);

	kvcp_out_stage u_out_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && emit),
		.result (result),
		.free   (out_free),
		.out_ch (out_ch)
	);
endmodule

@@ hdl/kvcp_in_stage.sv @@
// input register: holds one accepted byte until the parser consumes it
// depends on kvcp_pkg and kvcp_in_if
module kvcp_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	kvcp_in_if.sink    in_ch,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] char_s1
);
	import kvcp_pkg::*;

	logic take;

	assign in_ch.ready = !valid_s1 || advance;
	assign take = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_s1 <= in_ch.char_byte;
		end
	end
endmodule

@@ hdl/kvcp_parse_core.sv @@
// parser state, keyword match, value accumulation and stored settings
// depends on kvcp_pkg
module kvcp_parse_core #(
	parameter int VALUE_BITS = kvcp_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = kvcp_pkg::COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        char_s1,
	output logic              emit,
	output kvcp_pkg::result_t result
);
	import kvcp_pkg::*;

	localparam int ACC_W = VALUE_BITS + 4;

	phase_t                phase_q, phase_n;
	logic [3:0]            keypos_q, keypos_n;
	logic [2:0]            flags_q, flags_n;
	logic [VALUE_BITS-1:0] acc_q, acc_n;
	logic [COUNT_BITS-1:0] count_q, count_n;
	logic [VALUE_BITS-1:0] baud_q, baud_n;
	logic [VALUE_BITS-1:0] retries_q, retries_n;
	logic                  echo_q, echo_n;

	logic                  commit;
	logic                  is_digit;
	logic [7:0]            digit;
	logic [ACC_W-1:0]      acc_ext;
	logic [ACC_W-1:0]      acc_sum;
	logic                  acc_sat;
	logic [VALUE_BITS-1:0] acc_step;
	logic [VALUE_BITS+OUT_VALUE_W-1:0] baud_ext, retries_ext;
	logic [COUNT_BITS+OUT_COUNT_W-1:0] count_ext;

	// acc * 10 + digit by shifts, saturate when it leaves VALUE_BITS
	assign is_digit = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign digit    = char_s1 - CH_ZERO;
	assign acc_ext  = {4'b0000, acc_q};
	assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) + {{(ACC_W-8){1'b0}}, digit};
	assign acc_sat  = (acc_sum[ACC_W-1:VALUE_BITS] != 4'b0000);
	assign acc_step = acc_sat ? {VALUE_BITS{1'b1}} : acc_sum[VALUE_BITS-1:0];

	always_comb begin
		phase_n  = phase_q;
		keypos_n = keypos_q;
		flags_n  = flags_q;
		acc_n    = acc_q;
		count_n  = count_q;
		commit   = 1'b0;
		emit     = 1'b0;
		if (char_s1 == CH_END) begin
			emit     = 1'b1;
			commit   = (phase_q == PH_VALUE);
			phase_n  = PH_KEY;
			keypos_n = '0;
			flags_n  = FLAGS_ALL;
			acc_n    = '0;
			count_n  = '0;
		end else begin
			case (phase_q)
				PH_KEY: begin
					if (char_s1 == CH_SEMI) begin
						keypos_n = '0;
						flags_n  = FLAGS_ALL;
						acc_n    = '0;
					end else if (char_s1 == CH_EQUAL) begin
						if (keypos_q == KEY_LEN_SHORT) begin
							flags_n = flags_q & FLAGS_SHORT;
						end else if (keypos_q == KEY_LEN_LONG) begin
							flags_n = flags_q & FLAGS_LONG;
						end else begin
							flags_n = FLAGS_NONE;
						end
						if (count_q != {COUNT_BITS{1'b1}}) begin
							count_n = count_q + 1'b1;
						end
						acc_n   = '0;
						phase_n = PH_VALUE;
					end else begin
						flags_n = flags_q & kw_keep(keypos_q, char_s1);
						if (keypos_q != KEY_POS_MAX) begin
							keypos_n = keypos_q + 1'b1;
						end
					end
				end
				PH_VALUE: begin
					if (is_digit) begin
						acc_n = acc_step;
					end else begin
						commit = 1'b1;
						if (char_s1 == CH_SEMI) begin
							phase_n  = PH_KEY;
							keypos_n = '0;
							flags_n  = FLAGS_ALL;
							acc_n    = '0;
						end else begin
							phase_n = PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					if (char_s1 == CH_SEMI) begin
						phase_n  = PH_KEY;
						keypos_n = '0;
						flags_n  = FLAGS_ALL;
						acc_n    = '0;
					end
				end
				default: begin
					phase_n  = PH_KEY;
					keypos_n = '0;
					flags_n  = FLAGS_ALL;
					acc_n    = '0;
				end
			endcase
		end
	end

	// baud wins over retries, retries over echo
	always_comb begin
		baud_n    = baud_q;
		retries_n = retries_q;
		echo_n    = echo_q;
		if (commit) begin
			if (flags_q[FLAG_BAUD]) begin
				baud_n = acc_q;
			end else if (flags_q[FLAG_RETRIES]) begin
				retries_n = acc_q;
			end else if (flags_q[FLAG_ECHO]) begin
				echo_n = (acc_q != '0);
			end
		end
	end

	assign baud_ext    = {{OUT_VALUE_W{1'b0}}, baud_n};
	assign retries_ext = {{OUT_VALUE_W{1'b0}}, retries_n};
	assign count_ext   = {{OUT_COUNT_W{1'b0}}, count_q};

	assign result.baud    = baud_ext[OUT_VALUE_W-1:0];
	assign result.retries = retries_ext[OUT_VALUE_W-1:0];
	assign result.echo    = echo_n;
	assign result.count   = count_ext[OUT_COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_KEY;
			keypos_q  <= '0;
			flags_q   <= FLAGS_ALL;
			acc_q     <= '0;
			count_q   <= '0;
			baud_q    <= '0;
			retries_q <= '0;
			echo_q    <= 1'b0;
		end else if (fire) begin
			phase_q   <= phase_n;
			keypos_q  <= keypos_n;
			flags_q   <= flags_n;
			acc_q     <= acc_n;
			count_q   <= count_n;
			baud_q    <= baud_n;
			retries_q <= retries_n;
			echo_q    <= echo_n;
		end
	end
endmodule

@@ hdl/kvcp_out_stage.sv @@
// result register feeding the output channel
// depends on kvcp_pkg and kvcp_out_if
module kvcp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  kvcp_pkg::result_t result,
	output logic              free,
	kvcp_out_if.source        out_ch
);
	import kvcp_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign free = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign out_ch.valid         = valid_q;
	assign out_ch.baud_value    = data_q.baud;
	assign out_ch.retries_value = data_q.retries;
	assign out_ch.echo_enabled  = data_q.echo;
	assign out_ch.pairs_counted = data_q.count;
endmodule

@@ hdl/kvcp_checker.sv @@
// port-level checks for the key/value config parser, bound to the top level
// depends on kvcp_pkg and the assertion macros
`include "key_value_config_parser_macros.svh"

module kvcp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic [7:0]                       in_char,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [kvcp_pkg::OUT_VALUE_W-1:0] out_baud,
	input logic [kvcp_pkg::OUT_VALUE_W-1:0] out_retries,
	input logic                             out_echo,
	input logic [kvcp_pkg::OUT_COUNT_W-1:0] out_count
);
	import kvcp_pkg::*;

	// stalled result keeps its payload
	`KVCP_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(out_baud) && $stable(out_retries) && $stable(out_echo) && $stable(out_count), "result changed while stalled")

	// with the result register empty the input side never stalls
	`KVCP_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty result register")

	// a fresh result traces back to an accepted end-of-string byte
	`KVCP_ASSERT(a_result_cause, $rose(out_valid) |-> $past(in_valid && in_ready && (in_char == CH_END), 2), "result without end-of-string byte")
endmodule

bind key_value_config_parser kvcp_checker u_kvcp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.in_char     (in_ch.char_byte),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_baud    (out_ch.baud_value),
	.out_retries (out_ch.retries_value),
	.out_echo    (out_ch.echo_enabled),
	.out_count   (out_ch.pairs_counted)
);

@@ tb/key_value_config_parser_tb.sv @@
// self-checking testbench for key_value_config_parser: byte strings in, stored settings out
// depends on kvcp_pkg, kvcp_if.sv and the parser rtl
// a local parser model predicts each result, a posedge monitor checks them in order
module key_value_config_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import kvcp_pkg::*;

	localparam int VALUE_W = VALUE_BITS_DEF;
	localparam int COUNT_W = COUNT_BITS_DEF;
	localparam logic [63:0] VALUE_CAP = (64'd1 << VALUE_W) - 64'd1;
	localparam logic [COUNT_W-1:0] COUNT_CAP = '1;
	localparam int IDLE_PCT = 19;
	localparam int RANDOM_ITEMS = 1800;

	typedef struct {
		logic [7:0] ch;
		bit         drain;
	} backlog_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic drv_valid = 1'b0;
	logic [7:0] drv_char = 8'h00;
	logic drv_ready = 1'b0;
	logic in_taken = 1'b0;

	kvcp_in_if in_if ();
	kvcp_out_if out_if ();

	assign in_if.valid = drv_valid;
	assign in_if.char_byte = drv_char;
	assign out_if.ready = drv_ready;

	key_value_config_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_if),
		.out_ch(out_if)
	);

	backlog_item_t byte_backlog[$];
	result_t settings_due[$];
	bit drain_next = 1'b0;
	int taken_count = 0;
	int quiet_lo = 0;
	int quiet_hi = 0;
	int mismatches = 0;

	// parser model state
	phase_t phase = PH_KEY;
	logic [3:0] key_pos = '0;
	logic [2:0] key_cand = FLAGS_ALL;
	logic [63:0] digit_acc = '0;
	logic [COUNT_W-1:0] pairs_seen = '0;
	logic [OUT_VALUE_W-1:0] baud_setting = '0;
	logic [OUT_VALUE_W-1:0] retries_setting = '0;
	logic echo_setting = 1'b0;

	string keywords[3] = '{"baud", "retries", "echo"};

	initial forever #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatches++;
	endtask

	function automatic logic keyword_char(input string kw, input logic [3:0] pos,
		input logic [7:0] c);
		return (int'(pos) < kw.len()) && (8'(kw[pos]) == c);
	endfunction

	function automatic void clear_fragment();
		phase = PH_KEY;
		key_pos = '0;
		key_cand = FLAGS_ALL;
		digit_acc = '0;
	endfunction

	function automatic void commit_setting();
		if (key_cand[FLAG_BAUD])
			baud_setting = digit_acc[OUT_VALUE_W-1:0];
		else if (key_cand[FLAG_RETRIES])
			retries_setting = digit_acc[OUT_VALUE_W-1:0];
		else if (key_cand[FLAG_ECHO])
			echo_setting = (digit_acc != 0);
	endfunction

	function automatic void parse_byte(input logic [7:0] c);
		result_t r;
		logic [2:0] keep;
		logic [63:0] d;
		if (c == CH_END) begin
			if (phase == PH_VALUE)
				commit_setting();
			r.baud = baud_setting;
			r.retries = retries_setting;
			r.echo = echo_setting;
			r.count = pairs_seen[OUT_COUNT_W-1:0];
			settings_due.push_back(r);
			clear_fragment();
			pairs_seen = '0;
			return;
		end
		case (phase)
			PH_KEY: begin
				if (c == CH_SEMI) begin
					clear_fragment();
				end else if (c == CH_EQUAL) begin
					keep = FLAGS_NONE;
					if (key_pos == KEY_LEN_SHORT)
						keep = FLAGS_SHORT;
					if (key_pos == KEY_LEN_LONG)
						keep = FLAGS_LONG;
					key_cand &= keep;
					if (pairs_seen != COUNT_CAP)
						pairs_seen++;
					digit_acc = '0;
					phase = PH_VALUE;
				end else begin
					keep = FLAGS_NONE;
					keep[FLAG_BAUD] = keyword_char(keywords[0], key_pos, c);
					keep[FLAG_RETRIES] = keyword_char(keywords[1], key_pos, c);
					keep[FLAG_ECHO] = keyword_char(keywords[2], key_pos, c);
					key_cand &= keep;
					if (key_pos != KEY_POS_MAX)
						key_pos++;
				end
			end
			PH_VALUE: begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					d = 64'(c - CH_ZERO);
					// saturate instead of wrapping past the value width
					if (digit_acc > (VALUE_CAP - d) / 10)
						digit_acc = VALUE_CAP;
					else
						digit_acc = digit_acc * 10 + d;
				end else begin
					commit_setting();
					if (c == CH_SEMI)
						clear_fragment();
					else
						phase = PH_SKIP;
				end
			end
			default: begin
				if (c == CH_SEMI)
					clear_fragment();
			end
		endcase
	endfunction

	function automatic void push_byte(input logic [7:0] c);
		backlog_item_t it;
		it.ch = c;
		it.drain = drain_next;
		drain_next = 1'b0;
		byte_backlog.push_back(it);
	endfunction

	function automatic void push_text(input string s);
		foreach (s[i])
			push_byte(8'(s[i]));
	endfunction

	function automatic void push_junk(input int n);
		for (int i = 0; i < n; i++)
			push_byte(8'($urandom_range(255, 1)));
	endfunction

	function automatic void push_digits(input int n);
		for (int i = 0; i < n; i++)
			push_byte(CH_ZERO + 8'($urandom_range(9)));
	endfunction

	// one fragment of random shape: mostly real keys, some near misses and junk
	function automatic void push_fragment();
		int pick;
		int k;
		string kw;
		pick = $urandom_range(9);
		k = $urandom_range(2);
		kw = keywords[k];
		case (pick)
			0, 1, 2, 3: push_text(kw);
			4: push_text(kw.substr(0, kw.len() - 2));
			5: begin
				push_text(kw);
				push_junk(1);
			end
			6: begin
				kw[$urandom_range(kw.len() - 1)] = 8'($urandom_range(255, 1));
				push_text(kw);
			end
			7: push_junk($urandom_range(20, 1));
			8: push_text({kw, kw, kw});
			default: ;
		endcase
		if ($urandom_range(9) != 0) begin
			push_byte(CH_EQUAL);
			if ($urandom_range(7) == 0)
				push_digits($urandom_range(12, 9));
			else
				push_digits($urandom_range(4));
			if ($urandom_range(3) == 0)
				push_junk($urandom_range(3, 1));
		end
	endfunction

	function automatic void push_random_string();
		int n;
		if ($urandom_range(9) == 0) begin
			push_junk($urandom_range(30, 1));
		end else begin
			n = $urandom_range(4);
			for (int i = 0; i < n; i++) begin
				if (i != 0)
					push_byte(CH_SEMI);
				push_fragment();
			end
			if ($urandom_range(1) == 0)
				push_byte(CH_SEMI);
		end
		push_byte(CH_END);
	endfunction

	always @(negedge clk) begin
		backlog_item_t it;
		bit quiet;
		quiet = (taken_count >= quiet_lo) && (taken_count < quiet_hi);
		if (arst_n && (!drv_valid || in_taken)) begin
			if (byte_backlog.size() != 0 &&
				!(byte_backlog[0].drain && settings_due.size() != 0) &&
				(quiet || $urandom_range(99) >= IDLE_PCT)) begin
				it = byte_backlog.pop_front();
				drv_valid <= 1'b1;
				drv_char <= it.ch;
			end else begin
				drv_valid <= 1'b0;
			end
		end
		drv_ready <= arst_n && (quiet || $urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		result_t want;
		in_taken <= in_if.valid && in_if.ready;
		if (arst_n) begin
			if (out_if.valid && out_if.ready) begin
				if (settings_due.size() == 0) begin
					report_mismatch("result transaction with nothing expected");
				end else begin
					want = settings_due.pop_front();
					if (out_if.baud_value !== want.baud)
						report_mismatch($sformatf("baud_value got %0d expected %0d",
							out_if.baud_value, want.baud));
					if (out_if.retries_value !== want.retries)
						report_mismatch($sformatf("retries_value got %0d expected %0d",
							out_if.retries_value, want.retries));
					if (out_if.echo_enabled !== want.echo)
						report_mismatch($sformatf("echo_enabled got %0d expected %0d",
							out_if.echo_enabled, want.echo));
					if (out_if.pairs_counted !== want.count)
						report_mismatch($sformatf("pairs_counted got %0d expected %0d",
							out_if.pairs_counted, want.count));
				end
			end
			if (in_if.valid && in_if.ready) begin
				parse_byte(in_if.char_byte);
				taken_count++;
			end
		end
	end

	initial begin
		int random_base;
		// one past the value range, ending inside the digits
		push_text("baud=4294967296");
		push_byte(CH_END);
		// duplicate key, empty value, ignored tail with a top-bit byte
		push_text("echo=;retries=2;retries=9x");
		push_byte(8'hFF);
		push_text(";q");
		push_byte(CH_END);
		// long key and unknown keys still count
		push_text("echoechoecho0=5;");
		push_byte(8'hFF);
		push_text("=1;echo=0007");
		push_byte(CH_END);
		push_text("baud=;retries=4294967295");
		push_byte(CH_END);

		random_base = byte_backlog.size();
		quiet_lo = random_base + 300;
		quiet_hi = random_base + 700;
		while (byte_backlog.size() < random_base + RANDOM_ITEMS / 2)
			push_random_string();

		random_base = byte_backlog.size();
		drain_next = 1'b1;
		while (byte_backlog.size() < random_base + RANDOM_ITEMS / 2) begin
			if ($urandom_range(39) == 0)
				drain_next = 1'b1;
			push_random_string();
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (byte_backlog.size() != 0 || drv_valid)
			@(posedge clk);
		while (settings_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#8000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
